### sv/kdlq_pkg.sv
`default_nettype none

package kdlq_pkg;

    localparam int CMD_W       = 3;
    localparam int KEY_W       = 10;
    localparam int ST_W        = 2;
    localparam int CNT_W       = 11;
    localparam int LOG_W       = KEY_W + 1;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_REAR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOG_ADD    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOG_REMOVE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SYNC       = 3'd5;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [ST_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    // Write strobes from the link update logic to the node memories.
    typedef struct packed {
        logic present_we;
        logic present_bit;
        logic prev_we;
        logic next_we;
    } kdlq_wr_t;

endpackage

`default_nettype wire

### sv/keyed_doubly_linked_queue.sv
// Keyed doubly linked queue: an ordered set of keys kept as a linked list whose
// nodes are addressed directly by key.
// Input channel s_*: one transaction carries a command, a key and the sync
// direction. Output channel m_*: exactly one result per command, with the
// status, the member count, the front and rear keys and the pending log count.
// Add, remove, log and ignored commands read the node memories when accepted;
// in the execute state the links are updated and written back and the result
// register is loaded, and the block then returns to idle, where a new command
// can be accepted. Sync replays the log one entry at a time, reading the node
// and then updating it (the next log entry is read while the current one is
// written back), and loads its result with the last entry; a sync with an
// empty log behaves like an ignored command.
// One command is in flight at a time; s_tready is high while the block waits
// for a command, even if the previous result has not been taken.
// After reset the block sweeps the presence memory, one key per cycle, so
// s_tready stays low until the sweep is done.
// When the receiver stalls, the result register holds and the command in
// flight waits before its last memory write; a sync replays its earlier
// entries and holds only the last one.
`default_nettype none

module keyed_doubly_linked_queue
    import kdlq_pkg::*;
#(
    parameter int ENTRIES   = 1024,
    parameter int LOG_DEPTH = 1024
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // [2:0] command, [12:3] key, [13] sync_to_front, [15:14] zero
    input  wire  [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // [1:0] status, [12:2] member_count, [22:13] front_key, [32:23] rear_key,
    // [43:33] pending_count, [47:44] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int LFW = $clog2(LOG_DEPTH + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SNODE = 3'd3;
    localparam logic [2:0] S_SEXEC = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   rm_reg, rm_next;
    logic                   front_reg;
    logic [AW-1:0]          head_reg, head_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [LFW-1:0]         fill_reg, fill_next;
    logic [LFW-1:0]         sidx_reg, sidx_next;
    logic [ST_W-1:0]        first_reg, first_next;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_tdata_reg;

    logic [CMD_W-1:0] s_command;
    logic [KEY_W-1:0] s_key;
    logic             s_sync_to_front;
    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             apply_node;
    logic             key_ok;
    logic             sync_last;
    logic [LFW-1:0]   sidx_inc;
    logic [ST_W-1:0]  res_status;

    logic             present_rd;
    logic [AW-1:0]    prev_rd, next_rd;
    logic [AW-1:0]    node_rd_addr;
    logic             node_rd_en;
    logic             present_we, present_wdata;
    logic [AW-1:0]    present_waddr;
    logic [LOG_W-1:0] log_rd_data;
    logic             log_rd_en;
    logic [LAW-1:0]   log_rd_addr;
    logic             log_we;

    logic             op_remove, op_front;
    logic [ST_W-1:0]  op_status;
    kdlq_wr_t         op_wr;
    logic [AW-1:0]    op_prev_waddr, op_prev_wdata, op_next_waddr, op_next_wdata;
    logic [AW-1:0]    op_head, op_tail;
    logic [CW-1:0]    op_count;

    assign s_command       = s_tdata[CMD_W-1:0];
    assign s_key           = s_tdata[CMD_W+KEY_W-1:CMD_W];
    assign s_sync_to_front = s_tdata[CMD_W+KEY_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign key_ok    = (32'(key_reg) < ENTRIES);
    assign sidx_inc  = sidx_reg + LFW'(1);
    assign sync_last = (sidx_inc == fill_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;

    // During sync the node read follows the log entry read in the cycle before.
    assign node_rd_en   = accept || (state_reg == S_SNODE);
    assign node_rd_addr = (state_reg == S_SNODE) ? AW'(log_rd_data[KEY_W-1:0]) : AW'(s_key);

    assign op_remove = (state_reg == S_SEXEC) ? rm_reg : (cmd_reg == CMD_REMOVE);
    assign op_front  = (state_reg == S_SEXEC) ? front_reg : (cmd_reg == CMD_ADD_FRONT);

    assign present_we    = (state_reg == S_CLEAR) || (apply_node && op_wr.present_we);
    assign present_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : AW'(key_reg);
    assign present_wdata = (state_reg == S_CLEAR) ? 1'b0 : op_wr.present_bit;

    kdlq_link_op #(
        .ENTRIES (ENTRIES)
    ) u_link_op (
        .key        (key_reg),
        .is_remove  (op_remove),
        .to_front   (op_front),
        .present_rd (present_rd),
        .prev_rd    (prev_rd),
        .next_rd    (next_rd),
        .head       (head_reg),
        .tail       (tail_reg),
        .count      (count_reg),
        .status     (op_status),
        .wr         (op_wr),
        .prev_waddr (op_prev_waddr),
        .prev_wdata (op_prev_wdata),
        .next_waddr (op_next_waddr),
        .next_wdata (op_next_wdata),
        .head_next  (op_head),
        .tail_next  (op_tail),
        .count_next (op_count)
    );

    kdlq_ram #(
        .WIDTH (1),
        .DEPTH (ENTRIES)
    ) u_present_ram (
        .clk     (clk),
        .wr_en   (present_we),
        .wr_addr (present_waddr),
        .wr_data (present_wdata),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (present_rd)
    );

    kdlq_ram #(
        .WIDTH (AW),
        .DEPTH (ENTRIES)
    ) u_prev_ram (
        .clk     (clk),
        .wr_en   (apply_node && op_wr.prev_we),
        .wr_addr (op_prev_waddr),
        .wr_data (op_prev_wdata),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (prev_rd)
    );

    kdlq_ram #(
        .WIDTH (AW),
        .DEPTH (ENTRIES)
    ) u_next_ram (
        .clk     (clk),
        .wr_en   (apply_node && op_wr.next_we),
        .wr_addr (op_next_waddr),
        .wr_data (op_next_wdata),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (next_rd)
    );

    kdlq_ram #(
        .WIDTH (LOG_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk     (clk),
        .wr_en   (log_we),
        .wr_addr (LAW'(fill_reg)),
        .wr_data ({(cmd_reg == CMD_LOG_REMOVE), key_reg}),
        .rd_en   (log_rd_en),
        .rd_addr (log_rd_addr),
        .rd_data (log_rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        key_next    = key_reg;
        rm_next     = rm_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        fill_next   = fill_reg;
        sidx_next   = sidx_reg;
        first_next  = first_reg;
        res_status  = ST_OK;
        apply_node  = 1'b0;
        log_we      = 1'b0;
        log_rd_en   = 1'b0;
        log_rd_addr = '0;
        out_load    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == AW'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next   = s_key;
                    sidx_next  = '0;
                    first_next = ST_OK;
                    if ((s_command == CMD_SYNC) && (fill_reg != '0))
                    begin
                        log_rd_en  = 1'b1;
                        state_next = S_SNODE;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (cmd_reg)
                        CMD_ADD_FRONT, CMD_ADD_REAR, CMD_REMOVE:
                        begin
                            apply_node = 1'b1;
                            head_next  = op_head;
                            tail_next  = op_tail;
                            count_next = op_count;
                            res_status = op_status;
                        end
                        CMD_LOG_ADD, CMD_LOG_REMOVE:
                        begin
                            if (!key_ok)
                            begin
                                res_status = ST_ABSENT;
                            end
                            else if (fill_reg == LFW'(LOG_DEPTH))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                log_we    = 1'b1;
                                fill_next = fill_reg + LFW'(1);
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SNODE:
            begin
                key_next   = log_rd_data[KEY_W-1:0];
                rm_next    = log_rd_data[KEY_W];
                state_next = S_SEXEC;
            end
            S_SEXEC:
            begin
                if (!sync_last || out_free)
                begin
                    apply_node = 1'b1;
                    head_next  = op_head;
                    tail_next  = op_tail;
                    count_next = op_count;
                    if (first_reg == ST_OK)
                    begin
                        first_next = op_status;
                    end
                    res_status = first_next;
                    if (sync_last)
                    begin
                        out_load   = 1'b1;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Fetch the next entry while this one is written back.
                        log_rd_en   = 1'b1;
                        log_rd_addr = LAW'(sidx_inc);
                        sidx_next   = sidx_inc;
                        state_next  = S_SNODE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        rm_reg    <= rm_next;
        sidx_reg  <= sidx_next;
        first_reg <= first_next;
        if (accept)
        begin
            cmd_reg   <= s_command;
            front_reg <= s_sync_to_front;
        end
        if (out_load)
        begin
            out_tdata_reg <= {4'b0000,
                              CNT_W'(fill_next),
                              (count_next != '0) ? KEY_W'(tail_next) : KEY_W'(0),
                              (count_next != '0) ? KEY_W'(head_next) : KEY_W'(0),
                              CNT_W'(count_next),
                              res_status};
        end
    end

endmodule

`default_nettype wire

### sv/kdlq_ram.sv
`default_nettype none

module kdlq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                         clk,
    input  wire                                         wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                            wr_data,
    input  wire                                         rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/kdlq_link_op.sv
`default_nettype none

module kdlq_link_op
    import kdlq_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire  [KEY_W-1:0]                 key,
    input  wire                              is_remove,
    input  wire                              to_front,
    input  wire                              present_rd,
    input  wire  [$clog2(ENTRIES)-1:0]       prev_rd,
    input  wire  [$clog2(ENTRIES)-1:0]       next_rd,
    input  wire  [$clog2(ENTRIES)-1:0]       head,
    input  wire  [$clog2(ENTRIES)-1:0]       tail,
    input  wire  [$clog2(ENTRIES+1)-1:0]     count,
    output logic [ST_W-1:0]                  status,
    output kdlq_wr_t                         wr,
    output logic [$clog2(ENTRIES)-1:0]       prev_waddr,
    output logic [$clog2(ENTRIES)-1:0]       prev_wdata,
    output logic [$clog2(ENTRIES)-1:0]       next_waddr,
    output logic [$clog2(ENTRIES)-1:0]       next_wdata,
    output logic [$clog2(ENTRIES)-1:0]       head_next,
    output logic [$clog2(ENTRIES)-1:0]       tail_next,
    output logic [$clog2(ENTRIES+1)-1:0]     count_next
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic          key_ok;
    logic [AW-1:0] k;

    assign key_ok = (32'(key) < ENTRIES);
    assign k      = AW'(key);

    // The self links of a node added at one end are never read before they are
    // overwritten, so each add needs only one write per link memory.
    always_comb
    begin
        status     = ST_OK;
        wr         = '0;
        prev_waddr = k;
        prev_wdata = k;
        next_waddr = k;
        next_wdata = k;
        head_next  = head;
        tail_next  = tail;
        count_next = count;
        if (!key_ok)
        begin
            status = ST_ABSENT;
        end
        else if (!is_remove)
        begin
            if (present_rd)
            begin
                status = ST_PRESENT;
            end
            else
            begin
                wr.present_we  = 1'b1;
                wr.present_bit = 1'b1;
                wr.prev_we     = 1'b1;
                wr.next_we     = 1'b1;
                count_next     = count + CW'(1);
                if (count == '0)
                begin
                    head_next = k;
                    tail_next = k;
                end
                else if (to_front)
                begin
                    next_wdata = head;
                    prev_waddr = head;
                    head_next  = k;
                end
                else
                begin
                    prev_wdata = tail;
                    next_waddr = tail;
                    tail_next  = k;
                end
            end
        end
        else
        begin
            if (!present_rd)
            begin
                status = ST_ABSENT;
            end
            else
            begin
                wr.present_we  = 1'b1;
                wr.present_bit = 1'b0;
                if (count != '0)
                begin
                    count_next = count - CW'(1);
                end
                if (count <= CW'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                else if (k == head)
                begin
                    head_next = next_rd;
                end
                else if (k == tail)
                begin
                    tail_next = prev_rd;
                end
                else
                begin
                    // Unlink from the middle: the neighbors point past this node.
                    wr.next_we = 1'b1;
                    next_waddr = prev_rd;
                    next_wdata = next_rd;
                    wr.prev_we = 1'b1;
                    prev_waddr = next_rd;
                    prev_wdata = prev_rd;
                end
            end
        end
    end

endmodule

`default_nettype wire

### sv/kdlq_checker.sv
`default_nettype none

module kdlq_checker
    import kdlq_pkg::*;
#(
    parameter int ENTRIES   = 1024,
    parameter int LOG_DEPTH = 1024
) (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   s_tvalid,
    input wire                   s_tready,
    input wire [IN_TDATA_W-1:0]  s_tdata,
    input wire                   m_tvalid,
    input wire                   m_tready,
    input wire [OUT_TDATA_W-1:0] m_tdata
);

    // A held result must not change until the receiver takes it.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Commands are processed one at a time, so two cannot be accepted back to back.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !(s_tvalid && s_tready))
        else $error("command accepted while another is in flight");

    // An empty list reports zero for both end keys.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[12:2] == 11'd0) |-> (m_tdata[22:13] == 10'd0)
                                                && (m_tdata[32:23] == 10'd0))
        else $error("empty list reports nonzero end keys");

    // Counts stay within capacity and the padding bits of a result are zero.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[12:2]) <= ENTRIES) && (32'(m_tdata[43:33]) <= LOG_DEPTH)
                     && (m_tdata[47:44] == 4'd0))
        else $error("count beyond capacity or padding not zero");

    // A command that waits for the block stays unchanged until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("command changed while waiting");

endmodule

bind keyed_doubly_linked_queue kdlq_checker #(
    .ENTRIES   (ENTRIES),
    .LOG_DEPTH (LOG_DEPTH)
) u_kdlq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;
    import kdlq_pkg::*;

    localparam int KEYS      = 1024;
    localparam int LOG_SLOTS = 1024;

    // Command codes 6 and 7 are not decoded by the block.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] front;
        logic [KEY_W-1:0] rear;
        logic [CNT_W-1:0] pending;
    } queue_state_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    keyed_doubly_linked_queue #(
        .ENTRIES   (KEYS),
        .LOG_DEPTH (LOG_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow copy of the list and the deferred-operation log.
    bit               member [KEYS];
    logic [KEY_W-1:0] toward_front [KEYS];
    logic [KEY_W-1:0] toward_rear [KEYS];
    logic [KEY_W-1:0] front_idx;
    logic [KEY_W-1:0] rear_idx;
    int               members;
    logic [LOG_W-1:0] deferred [LOG_SLOTS];
    int               deferred_len;

    queue_state_t expected_q[$];

    int  mismatches;
    int  items_sent;
    int  results_checked;
    int  peak_members;
    int  peak_pending;
    bit  src_steady;
    bit  sink_steady;

    function automatic logic [ST_W-1:0] link_in(logic [KEY_W-1:0] k, bit at_front);
        if (member[k])
            return ST_PRESENT;
        member[k] = 1'b1;
        toward_front[k] = k;
        toward_rear[k] = k;
        if (members == 0)
        begin
            front_idx = k;
            rear_idx = k;
        end
        else if (at_front)
        begin
            toward_rear[k] = front_idx;
            toward_front[front_idx] = k;
            front_idx = k;
        end
        else
        begin
            toward_front[k] = rear_idx;
            toward_rear[rear_idx] = k;
            rear_idx = k;
        end
        members++;
        return ST_OK;
    endfunction

    function automatic logic [ST_W-1:0] unlink(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] p;
        logic [KEY_W-1:0] n;
        if (!member[k])
            return ST_ABSENT;
        if (members <= 1)
        begin
            front_idx = '0;
            rear_idx = '0;
        end
        else if (k == front_idx)
            front_idx = toward_rear[k];
        else if (k == rear_idx)
            rear_idx = toward_front[k];
        else
        begin
            p = toward_front[k];
            n = toward_rear[k];
            toward_rear[p] = n;
            toward_front[n] = p;
        end
        member[k] = 1'b0;
        if (members > 0)
            members--;
        return ST_OK;
    endfunction

    function automatic logic [ST_W-1:0] defer(logic [KEY_W-1:0] k, bit is_remove);
        if (deferred_len >= LOG_SLOTS)
            return ST_FULL;
        deferred[deferred_len] = {is_remove, k};
        deferred_len++;
        return ST_OK;
    endfunction

    // Replays the log in order; the first failing entry sets the status.
    function automatic logic [ST_W-1:0] replay_deferred(bit at_front);
        logic [ST_W-1:0] first_st;
        logic [ST_W-1:0] st;
        first_st = ST_OK;
        for (int i = 0; i < deferred_len; i++)
        begin
            if (deferred[i][LOG_W-1])
                st = unlink(deferred[i][KEY_W-1:0]);
            else
                st = link_in(deferred[i][KEY_W-1:0], at_front);
            if (first_st == ST_OK)
                first_st = st;
        end
        deferred_len = 0;
        return first_st;
    endfunction

    function automatic queue_state_t apply_command(logic [CMD_W-1:0] cmd,
                                                   logic [KEY_W-1:0] key, bit to_front);
        queue_state_t r;
        logic [ST_W-1:0] st;
        case (cmd)
            CMD_ADD_FRONT:  st = link_in(key, 1'b1);
            CMD_ADD_REAR:   st = link_in(key, 1'b0);
            CMD_REMOVE:     st = unlink(key);
            CMD_LOG_ADD:    st = defer(key, 1'b0);
            CMD_LOG_REMOVE: st = defer(key, 1'b1);
            CMD_SYNC:       st = replay_deferred(to_front);
            default:        st = ST_OK;
        endcase
        if (members > peak_members)
            peak_members = members;
        if (deferred_len > peak_pending)
            peak_pending = deferred_len;
        r.status  = st;
        r.count   = CNT_W'(members);
        r.front   = (members != 0) ? front_idx : '0;
        r.rear    = (members != 0) ? rear_idx : '0;
        r.pending = CNT_W'(deferred_len);
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] any_member();
        logic [KEY_W-1:0] k;
        k = KEY_W'($urandom_range(0, KEYS - 1));
        for (int i = 0; i < KEYS; i++)
        begin
            if (member[k])
                return k;
            k = k + 1'b1;
        end
        return '0;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("tb: mismatch at result %0d: %s", results_checked, msg);
    endtask

    // Drives one command, waits for its transaction and records the expected result.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, bit to_front);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, to_front, key, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        expected_q.push_back(apply_command(cmd, key, to_front));
        items_sent++;
    endtask

    task automatic test_directed();
        send_command(CMD_SYNC, 10'd0, 1'b0);
        send_command(CMD_REMOVE, 10'd5, 1'b0);
        send_command(CMD_ADD_FRONT, 10'd0, 1'b0);
        send_command(CMD_ADD_REAR, 10'd1023, 1'b1);
        send_command(CMD_ADD_FRONT, 10'd0, 1'b1);
        send_command(CMD_ADD_REAR, 10'd1023, 1'b0);
        send_command(CMD_ADD_REAR, 10'd512, 1'b0);
        send_command(CMD_ADD_FRONT, 10'd341, 1'b0);
        send_command(CMD_REMOVE, 10'd1023, 1'b0);
        send_command(CMD_REMOVE, 10'd512, 1'b0);
        send_command(CMD_REMOVE, 10'd341, 1'b0);
        send_command(CMD_SPARE_A, 10'd1023, 1'b1);
        send_command(CMD_SPARE_B, 10'd682, 1'b0);
        send_command(CMD_LOG_ADD, 10'd100, 1'b0);
        send_command(CMD_LOG_ADD, 10'd0, 1'b0);
        send_command(CMD_LOG_REMOVE, 10'd200, 1'b0);
        send_command(CMD_LOG_REMOVE, 10'd100, 1'b0);
        send_command(CMD_LOG_ADD, 10'd1023, 1'b0);
        send_command(CMD_SYNC, 10'd0, 1'b1);
        send_command(CMD_LOG_ADD, 10'd5, 1'b0);
        send_command(CMD_LOG_ADD, 10'd6, 1'b0);
        send_command(CMD_SYNC, 10'd1023, 1'b0);
        send_command(CMD_REMOVE, 10'd0, 1'b0);
    endtask

    // Mostly small keys so that adds and removes keep colliding with members.
    task automatic test_random_mix(int count, int remove_bias);
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < remove_bias)
                cmd = CMD_REMOVE;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)      cmd = CMD_ADD_FRONT;
                else if (pick < 50) cmd = CMD_ADD_REAR;
                else if (pick < 62) cmd = CMD_REMOVE;
                else if (pick < 76) cmd = CMD_LOG_ADD;
                else if (pick < 86) cmd = CMD_LOG_REMOVE;
                else if (pick < 95) cmd = CMD_SYNC;
                else if (pick < 98) cmd = CMD_SPARE_A;
                else                cmd = CMD_SPARE_B;
            end
            pick = $urandom_range(0, 99);
            if ((cmd == CMD_REMOVE || cmd == CMD_LOG_REMOVE) && members > 0 && pick < 50)
                key = any_member();
            else if (pick < 80)
                key = KEY_W'($urandom_range(0, 31));
            else if (pick < 88)
                key = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            else
                key = KEY_W'($urandom_range(0, KEYS - 1));
            send_command(cmd, key, 1'($urandom_range(0, 1)));
        end
    endtask

    // Logs every key once, overflows the log, then syncs to a completely full list.
    task automatic test_log_fill();
        logic [KEY_W-1:0] order [KEYS];
        logic [KEY_W-1:0] tmp;
        int j;
        for (int i = 0; i < KEYS; i++)
            order[i] = KEY_W'(i);
        for (int i = KEYS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        send_command(CMD_SYNC, KEY_W'($urandom_range(0, KEYS - 1)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < KEYS; i++)
            send_command(CMD_LOG_ADD, order[i], 1'($urandom_range(0, 1)));
        send_command(CMD_LOG_ADD, KEY_W'($urandom_range(0, KEYS - 1)), 1'b0);
        send_command(CMD_LOG_REMOVE, KEY_W'($urandom_range(0, KEYS - 1)), 1'b1);
        send_command(CMD_SYNC, KEY_W'($urandom_range(0, KEYS - 1)), 1'($urandom_range(0, 1)));
        send_command(CMD_ADD_REAR, KEY_W'($urandom_range(0, KEYS - 1)), 1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin : result_checker
        int stall;
        queue_state_t got;
        queue_state_t want;
        m_tready = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got = {m_tdata[1:0], m_tdata[12:2], m_tdata[22:13], m_tdata[32:23],
                   m_tdata[43:33]};
            results_checked++;
            if (expected_q.size() == 0)
                report_mismatch($sformatf("result with nothing outstanding, tdata %h", m_tdata));
            else
            begin
                want = expected_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.count !== want.count)
                    report_mismatch($sformatf("member_count %0d, want %0d", got.count, want.count));
                if (got.front !== want.front)
                    report_mismatch($sformatf("front_key %0d, want %0d", got.front, want.front));
                if (got.rear !== want.rear)
                    report_mismatch($sformatf("rear_key %0d, want %0d", got.rear, want.rear));
                if (got.pending !== want.pending)
                    report_mismatch($sformatf("pending_count %0d, want %0d",
                                              got.pending, want.pending));
                if (m_tdata[47:44] !== 4'b0000)
                    report_mismatch($sformatf("padding bits %b", m_tdata[47:44]));
            end
        end
    end

    initial
    begin
        int waited;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(130, 0);
        test_log_fill();
        test_random_mix(140, 55);
        test_random_mix(130, 0);
        s_tvalid <= 1'b0;

        waited = 0;
        while (expected_q.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        while (expected_q.size() != 0)
        begin
            void'(expected_q.pop_front());
            report_mismatch("result never arrived");
        end

        $display("tb: %0d commands sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatches);
        $display("tb: list peaked at %0d keys, log at %0d pending entries",
                 peak_members, peak_pending);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
